FILE: src/dlx_pkg.sv
package dlx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned RegW   = 5;
  localparam int unsigned OfsW   = 32;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned PhaseW = 2;

  // decoder phase codes
  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_LEN  = 2'd1;
  localparam logic [PhaseW-1:0] PH_OP   = 2'd2;
  localparam logic [PhaseW-1:0] PH_OFS  = 2'd3;

  // result kinds
  localparam logic [KindW-1:0] KIND_REG     = 3'd0;
  localparam logic [KindW-1:0] KIND_LIT     = 3'd1;
  localparam logic [KindW-1:0] KIND_BREG    = 3'd2;
  localparam logic [KindW-1:0] KIND_REG_OOR = 3'd3;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd4;

  // opcode ranges
  localparam logic [ByteW-1:0] OP_LIT_LO  = 8'h30;
  localparam logic [ByteW-1:0] OP_LIT_HI  = 8'h4f;
  localparam logic [ByteW-1:0] OP_REG_LO  = 8'h50;
  localparam logic [ByteW-1:0] OP_REG_HI  = 8'h6f;
  localparam logic [ByteW-1:0] OP_BREG_LO = 8'h70;
  localparam logic [ByteW-1:0] OP_BREG_HI = 8'h8f;

  localparam logic [ShiftW-1:0] LEB_STEP  = 6'd7;
  localparam logic [ShiftW-1:0] SHIFT_LIM = 6'd32;
  localparam logic [RegW-1:0]   MAX_REG_RST = 5'd15;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [OfsW-1:0]   acc;
    logic [ShiftW-1:0] shift;
    logic [RegW-1:0]   held_reg;
  } dlx_state_t;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [RegW-1:0]        regno;
    logic signed [OfsW-1:0] offset_value;
  } dlx_res_t;

endpackage

FILE: src/dlx_if.sv
interface dlx_byte_if;
  import dlx_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             start_req;
  modport source (output valid, byte_in, start_req, input ready);
  modport sink   (input valid, byte_in, start_req, output ready);
endinterface

interface dlx_res_if;
  import dlx_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  logic [RegW-1:0]        regno;
  logic signed [OfsW-1:0] offset_value;
  modport source (output valid, kind, regno, offset_value, input ready);
  modport sink   (input valid, kind, regno, offset_value, output ready);
endinterface

interface dlx_cfg_if;
  import dlx_pkg::*;
  logic            valid;
  logic            ready;
  logic [RegW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/dlx_decode.sv
module dlx_decode
  import dlx_pkg::*;
(
  input  dlx_state_t       state_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             start_i,
  input  logic [RegW-1:0]  max_reg_i,
  output dlx_state_t       state_o,
  output logic             res_valid_o,
  output dlx_res_t         res_o
);

  logic [PhaseW-1:0] phase;
  logic [ByteW-1:0]  reg_diff;
  logic [ByteW-1:0]  lit_diff;
  logic [ByteW-1:0]  breg_diff;
  logic [RegW-1:0]   reg_num;
  logic [RegW-1:0]   breg_num;
  logic              is_reg;
  logic              is_lit;
  logic              is_breg;
  logic              shift_ok;
  logic [OfsW-1:0]   acc_or;
  logic [ShiftW-1:0] shift_nx;

  always_comb begin
    phase     = start_i ? PH_LEN : state_i.phase;
    reg_diff  = byte_i - OP_REG_LO;
    lit_diff  = byte_i - OP_LIT_LO;
    breg_diff = byte_i - OP_BREG_LO;
    reg_num   = reg_diff[RegW-1:0];
    breg_num  = breg_diff[RegW-1:0];
    is_reg    = (byte_i >= OP_REG_LO) && (byte_i <= OP_REG_HI);
    is_lit    = (byte_i >= OP_LIT_LO) && (byte_i <= OP_LIT_HI);
    is_breg   = (byte_i >= OP_BREG_LO) && (byte_i <= OP_BREG_HI);
    shift_ok  = state_i.shift < SHIFT_LIM;
    acc_or    = state_i.acc;
    shift_nx  = state_i.shift;
    if (shift_ok) begin
      acc_or   = state_i.acc | ({{(OfsW-7){1'b0}}, byte_i[6:0]} << state_i.shift);
      shift_nx = state_i.shift + LEB_STEP;
    end

    state_o     = state_i;
    state_o.phase = phase;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase)
      PH_LEN: begin
        if (!byte_i[7]) state_o.phase = PH_OP;
      end
      PH_OP: begin
        priority if (is_reg) begin
          res_valid_o = 1'b1;
          res_o.regno = reg_num;
          res_o.kind  = (reg_num <= max_reg_i) ? KIND_REG : KIND_REG_OOR;
        end else if (is_lit) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_LIT;
          res_o.offset_value = {{(OfsW-ByteW){1'b0}}, lit_diff};
        end else if (is_breg) begin
          if (breg_num > max_reg_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_REG_OOR;
            res_o.regno = breg_num;
          end else begin
            state_o.phase    = PH_OFS;
            state_o.held_reg = breg_num;
            state_o.acc      = '0;
            state_o.shift    = '0;
          end
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_UNKNOWN;
        end
      end
      PH_OFS: begin
        state_o.acc   = acc_or;
        state_o.shift = shift_nx;
        if (!byte_i[7]) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BREG;
          res_o.regno = state_i.held_reg;
          // sign-extend only when the last group ended inside the word
          if ((shift_nx < SHIFT_LIM) && byte_i[6]) begin
            res_o.offset_value = acc_or | ({OfsW{1'b1}} << shift_nx);
          end else begin
            res_o.offset_value = acc_or;
          end
        end
      end
      default: ;
    endcase

    if (res_valid_o) state_o.phase = PH_IDLE;
  end

endmodule

FILE: src/dlx_out_reg.sv
module dlx_out_reg
  import dlx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  dlx_res_t res_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output dlx_res_t out_res_o,
  output logic     free_o
);

  logic     valid_q, valid_d;
  dlx_res_t res_q;

  // a new word may enter when the slot is empty or drains this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: src/dwarf_location_expr_decoder_unit.sv
// DWARF location expression decoder.
// byte_if_i carries the expression one byte per word; start_req marks the
// first byte (of the leading ULEB128 length) of a new expression and always
// drops any expression in progress. After the length comes one opcode:
// lit0..31, reg0..31 or breg0..31, the latter followed by an SLEB128 offset.
// res_if_o carries one word per decoded expression (kind, regno,
// offset_value); bytes arriving after a result are dropped until next start.
// cfg_if_i writes max_register; it is always ready and should only be
// written while the block is idle.
// Throughput: one byte per cycle. Each byte is decoded by a single level of
// logic against the phase registers and the result lands in an output
// register, so a result appears in the cycle after its last byte is accepted.
// A full result register that the receiver stalls holds the input off
// (ready low) only while it cannot drain; otherwise bytes keep flowing.
// Reset: decoder idle, ignoring bytes until a start, max_register = 15,
// no result pending.
module dwarf_location_expr_decoder_unit
  import dlx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  dlx_byte_if.sink  byte_if_i,
  dlx_res_if.source res_if_o,
  dlx_cfg_if.sink   cfg_if_i
);

  dlx_state_t      st_q, st_d;
  logic [RegW-1:0] max_reg_q;
  logic            in_acc;
  logic            res_valid;
  logic            free;
  logic            out_valid;
  dlx_res_t        res;
  dlx_res_t        out_res;

  assign cfg_if_i.ready  = 1'b1;
  assign byte_if_i.ready = free;
  assign in_acc          = byte_if_i.valid && free;

  dlx_decode u_decode (
    .state_i     (st_q),
    .byte_i      (byte_if_i.byte_in),
    .start_i     (byte_if_i.start_req),
    .max_reg_i   (max_reg_q),
    .state_o     (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dlx_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc && res_valid),
    .res_i       (res),
    .out_ready_i (res_if_o.ready),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .free_o      (free)
  );

  assign res_if_o.valid        = out_valid;
  assign res_if_o.kind         = out_res.kind;
  assign res_if_o.regno        = out_res.regno;
  assign res_if_o.offset_value = out_res.offset_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      max_reg_q <= MAX_REG_RST;
    end else begin
      if (in_acc) st_q <= st_d;
      if (cfg_if_i.valid) max_reg_q <= cfg_if_i.data;
    end
  end

`ifndef SYNTH
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (st_q.phase == PH_IDLE) && !byte_if_i.start_req |=> !out_valid)
    else $error("result produced from an idle byte");

  a_breg_enters_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !byte_if_i.start_req && (st_q.phase == PH_OP) &&
    (byte_if_i.byte_in >= OP_BREG_LO) && (byte_if_i.byte_in <= OP_BREG_HI) &&
    (byte_if_i.byte_in - OP_BREG_LO <= {3'b000, max_reg_q})
    |=> (st_q.phase == PH_OFS) && (st_q.shift == '0) && (st_q.acc == '0))
    else $error("in-range breg did not start offset decode");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_res.kind != KIND_LIT) && (out_res.kind != KIND_BREG)
    |-> (out_res.offset_value == '0))
    else $error("nonzero offset on a kind without offset");

  a_shift_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.shift == 6'd0) || (st_q.shift == 6'd7) || (st_q.shift == 6'd14) ||
    (st_q.shift == 6'd21) || (st_q.shift == 6'd28) || (st_q.shift == 6'd35))
    else $error("offset shift left the 7-bit grid");

  a_result_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid |=> out_valid && (st_q.phase == PH_IDLE))
    else $error("result not registered or decoder not idle after it");
`endif

endmodule
